// File: src/pvte_pkg.sv
// Package for the polygon vertex transform engine.
// Holds sizes, opcode and status codes, register indexes, the sequencer state type and a saturating helper.
// No dependencies.
package pvte_pkg;
  localparam int MaxPoints = 64;
  localparam int CoordBits = 16;
  localparam int IdxBits = $clog2(MaxPoints);
  localparam int CntBits = $clog2(MaxPoints + 1);
  localparam int SumBits = CoordBits + IdxBits + 1;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_CLEAR = 3'd1, OP_TRANSLATE = 3'd2, OP_SCALE = 3'd3,
    OP_ROTATE = 3'd4, OP_MIRROR_MAX = 3'd5, OP_MIRROR_MIN = 3'd6, OP_READ = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2, ST_DISABLED = 2'd3
  } status_t;

  localparam logic [2:0] REG_VIEW_WIDTH = 3'd0;
  localparam logic [2:0] REG_VIEW_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SCALE_X = 3'd2;
  localparam logic [2:0] REG_SCALE_Y = 3'd3;
  localparam logic [2:0] REG_DRAWING = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN, S_DIV, S_WALK_RD, S_WALK, S_MUL, S_WB, S_RESP, S_READ_RD,
    S_READ_OUT
  } state_t;

  function automatic logic signed [CoordBits-1:0] sat(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd1 <<< (CoordBits - 1);
    hi = hi - 48'sd1;
    lo = -hi - 48'sd1;
    if (v > hi) return hi[CoordBits-1:0];
    if (v < lo) return lo[CoordBits-1:0];
    return v[CoordBits-1:0];
  endfunction
endpackage

// File: src/pvte_if.sv
// Channel interfaces for the polygon vertex transform engine.
// Depends on pvte_pkg.
interface pvte_cmd_if import pvte_pkg::*; ();
  logic valid;
  logic ready;
  logic [2:0] opcode;
  logic signed [CoordBits-1:0] coord_x;
  logic signed [CoordBits-1:0] coord_y;
  modport source (output valid, opcode, coord_x, coord_y, input ready);
  modport sink (input valid, opcode, coord_x, coord_y, output ready);
endinterface

interface pvte_res_if import pvte_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [CoordBits-1:0] point_x;
  logic signed [CoordBits-1:0] point_y;
  logic point_valid;
  logic last_of_run;
  logic [6:0] point_count;
  logic [1:0] status;
  modport source (output valid, point_x, point_y, point_valid, last_of_run, point_count,
                  status, input ready);
  modport sink (input valid, point_x, point_y, point_valid, last_of_run, point_count,
                status, output ready);
endinterface

interface pvte_cfg_if ();
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/polygon_vertex_transform_engine.sv
// Polygon vertex transform engine: vertex store and command sequencer.
// Depends on pvte_pkg and the channel interfaces in pvte_if.sv.
//
// Usage. Commands arrive on cmd (opcode, coord_x, coord_y); results leave on
// res; registers are written on cfg (index 0..4, wider data is masked, other
// indexes ignored). Vertices live in two synchronous RAMs of MaxPoints entries
// with a registered read. One command is handled at a time.
// Add and clear answer directly. Translate and scale walk the store vertex by
// vertex (read, multiply, compute, write back). Mirror walks the store once
// for the extreme x then once to rewrite it. Rotate walks once for the sums,
// then runs a restoring divider by the count, both axes at once, then
// rewrites. Read gives one result per vertex.
// Reset clears the count and the registers to their defaults; the stores are
// undefined but never used at or above the count. A stalled receiver holds the
// result register and the sequencer waits; cmd is ready only when idle.
module polygon_vertex_transform_engine
  import pvte_pkg::*;
(
  input logic clk,
  input logic rst,
  pvte_cmd_if.sink cmd,
  pvte_res_if.source res,
  pvte_cfg_if.sink cfg
);
  logic signed [CoordBits-1:0] xmem [MaxPoints];
  logic signed [CoordBits-1:0] ymem [MaxPoints];
  logic signed [CoordBits-1:0] rdx, rdy;
  logic [IdxBits-1:0] raddr, waddr;
  logic we;
  logic signed [CoordBits-1:0] wdx, wdy;

  logic [14:0] view_width, view_height;
  logic [11:0] scale_x, scale_y;
  logic drawing_enabled;

  state_t state, state_next;
  logic [2:0] op;
  logic signed [CoordBits-1:0] ox, oy;
  logic signed [CoordBits-1:0] wx, wy;
  logic [CntBits-1:0] count;
  logic [CntBits-1:0] idx;
  logic signed [SumBits-1:0] sx, sy;
  logic signed [CoordBits-1:0] m, cxr, cyr;
  logic signed [47:0] px, py;
  logic [SumBits-1:0] qx, qy, remx, remy, numx, numy;
  logic [5:0] dcnt;
  logic [1:0] rstatus;
  logic signed [CoordBits-1:0] nx, ny;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      view_width <= 15'd640; view_height <= 15'd480;
      scale_x <= 12'd282; scale_y <= 12'd307; drawing_enabled <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_VIEW_WIDTH: view_width <= cfg.data[14:0];
        REG_VIEW_HEIGHT: view_height <= cfg.data[14:0];
        REG_SCALE_X: scale_x <= cfg.data[11:0];
        REG_SCALE_Y: scale_y <= cfg.data[11:0];
        REG_DRAWING: drawing_enabled <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      xmem[waddr] <= wdx;
      ymem[waddr] <= wdy;
    end
    rdx <= xmem[raddr];
    rdy <= ymem[raddr];
  end

  assign raddr = idx[IdxBits-1:0];
  assign cmd.ready = (state == S_IDLE);
  wire last = (idx + 1'b1 == count);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.valid) begin
        if (cmd.opcode == OP_ADD || cmd.opcode == OP_CLEAR || count == '0)
          state_next = S_RESP;
        else if (cmd.opcode == OP_READ) state_next = S_READ_RD;
        else if (cmd.opcode inside {OP_ROTATE, OP_MIRROR_MAX, OP_MIRROR_MIN})
          state_next = S_SCAN_RD;
        else state_next = S_WALK_RD;
      end
      S_SCAN_RD: state_next = S_SCAN;
      S_SCAN: state_next = last ? (op == OP_ROTATE ? S_DIV : S_WALK_RD) : S_SCAN_RD;
      S_DIV: if (dcnt == 6'(SumBits - 1)) state_next = S_WALK_RD;
      S_WALK_RD: state_next = S_WALK;
      S_WALK: state_next = S_MUL;
      S_MUL: state_next = S_WB;
      S_WB: state_next = last ? S_RESP : S_WALK_RD;
      S_RESP: if (res.valid && res.ready) state_next = S_IDLE;
      S_READ_RD: state_next = S_READ_OUT;
      S_READ_OUT: if (res.valid && res.ready) state_next = last ? S_IDLE : S_READ_RD;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    logic signed [47:0] tx, ty;
    logic signed [47:0] sxw, syw;
    tx = '0; ty = '0;
    sxw = px >>> 8; syw = py >>> 8;
    if (px < 0 && px[7:0] != '0) sxw = sxw + 48'sd1;
    if (py < 0 && py[7:0] != '0) syw = syw + 48'sd1;
    case (op)
      OP_TRANSLATE: begin tx = 48'(rdx) + 48'(ox); ty = 48'(rdy) + 48'(oy); end
      OP_SCALE: begin
        tx = sxw; ty = syw;
        if (sxw > 48'(view_width) || sxw < 0 || syw > 48'(view_height) || syw < 0) begin
          tx = 48'(view_width); ty = 48'(view_height);
        end
      end
      OP_ROTATE: begin
        tx = 48'(cxr) - (48'(rdy) - 48'(cyr));
        ty = 48'(cyr) + (48'(rdx) - 48'(cxr));
      end
      default: begin tx = 48'sd2 * 48'(m) - 48'(rdx); ty = 48'(rdy); end
    endcase
    nx = sat(tx); ny = sat(ty);
  end

  assign we = (state == S_WB) || (state == S_IDLE && cmd.valid && cmd.opcode == OP_ADD &&
              drawing_enabled && count < CntBits'(MaxPoints));
  assign waddr = (state == S_IDLE) ? count[IdxBits-1:0] : idx[IdxBits-1:0];
  assign wdx = (state == S_IDLE) ? cmd.coord_x : wx;
  assign wdy = (state == S_IDLE) ?
      sat(48'(view_height) - 48'(cmd.coord_y)) : wy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res.valid && res.ready) res.valid <= 1'b0;
      case (state)
        S_IDLE: if (cmd.valid) begin
          op <= cmd.opcode; ox <= cmd.coord_x; oy <= cmd.coord_y;
          idx <= '0; sx <= '0; sy <= '0; rstatus <= ST_OK;
          if (cmd.opcode == OP_ADD) begin
            if (!drawing_enabled) rstatus <= ST_DISABLED;
            else if (count >= CntBits'(MaxPoints)) rstatus <= ST_FULL;
            else count <= count + 1'b1;
          end else if (cmd.opcode == OP_CLEAR) count <= '0;
          else if (count == '0) rstatus <= ST_EMPTY;
        end
        S_SCAN: begin
          if (idx == '0 || (op == OP_MIRROR_MAX && rdx > m) ||
              (op == OP_MIRROR_MIN && rdx < m)) m <= rdx;
          if (last) begin
            idx <= '0;
            numx <= (sx + SumBits'(rdx)) < 0 ? -(sx + SumBits'(rdx)) : (sx + SumBits'(rdx));
            numy <= (sy + SumBits'(rdy)) < 0 ? -(sy + SumBits'(rdy)) : (sy + SumBits'(rdy));
            sx <= sx + SumBits'(rdx); sy <= sy + SumBits'(rdy);
            remx <= '0; remy <= '0; dcnt <= '0;
          end else begin
            sx <= sx + SumBits'(rdx); sy <= sy + SumBits'(rdy);
            idx <= idx + 1'b1;
          end
        end
        S_DIV: begin
          logic [SumBits:0] trx, try_;
          trx = {remx, numx[SumBits-1]};
          try_ = {remy, numy[SumBits-1]};
          numx <= numx << 1; numy <= numy << 1;
          if (trx >= (SumBits+1)'(count)) begin
            remx <= SumBits'(trx - (SumBits+1)'(count)); qx <= {qx[SumBits-2:0], 1'b1};
          end else begin remx <= SumBits'(trx); qx <= {qx[SumBits-2:0], 1'b0}; end
          if (try_ >= (SumBits+1)'(count)) begin
            remy <= SumBits'(try_ - (SumBits+1)'(count)); qy <= {qy[SumBits-2:0], 1'b1};
          end else begin remy <= SumBits'(try_); qy <= {qy[SumBits-2:0], 1'b0}; end
          dcnt <= dcnt + 1'b1;
          if (dcnt == 6'(SumBits - 1)) begin
            cxr <= CoordBits'(sx[SumBits-1] ? -$signed({qx[SumBits-2:0], trx >= (SumBits+1)'(count)})
                                             : $signed({qx[SumBits-2:0], trx >= (SumBits+1)'(count)}));
            cyr <= CoordBits'(sy[SumBits-1] ? -$signed({qy[SumBits-2:0], try_ >= (SumBits+1)'(count)})
                                             : $signed({qy[SumBits-2:0], try_ >= (SumBits+1)'(count)}));
          end
        end
        S_WALK: begin
          px <= 48'(rdx) * $signed({1'b0, scale_x});
          py <= 48'(rdy) * $signed({1'b0, scale_y});
        end
        S_MUL: begin wx <= nx; wy <= ny; end
        S_WB: begin
          if (!last) idx <= idx + 1'b1;
        end
        default: ;
      endcase
      if (state == S_RESP && !res.valid && !(res.valid && res.ready)) begin
        res.valid <= 1'b1; res.point_x <= '0; res.point_y <= '0;
        res.point_valid <= 1'b0; res.last_of_run <= 1'b1;
        res.point_count <= 7'(count); res.status <= rstatus;
      end
      if (state == S_READ_OUT && !res.valid) begin
        res.valid <= 1'b1; res.point_x <= rdx; res.point_y <= rdy;
        res.point_valid <= 1'b1; res.last_of_run <= last;
        res.point_count <= 7'(count); res.status <= ST_OK;
      end
      if (state == S_READ_OUT && res.valid && res.ready && !last) idx <= idx + 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CntBits'(MaxPoints))
    else $error("vertex count beyond store depth");
  assert property (@(posedge clk) disable iff (rst) cmd.ready |-> state == S_IDLE)
    else $error("command taken while busy");
  assert property (@(posedge clk) disable iff (rst) res.valid && !res.ready |=> res.valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
      (state == S_WB) |-> (op != OP_READ && op != OP_ADD && op != OP_CLEAR))
    else $error("write-back for a command without a walk");
endmodule
